### rtl/ubds_pkg.sv
package ubds_pkg;

  // Field widths
  localparam int unsigned KHZ_W   = 16;
  localparam int unsigned BAUD_W  = 23;
  localparam int unsigned RATIO_W = 6;
  localparam int unsigned BDIV_W  = 13;

  // Datapath widths: clock in Hz fits 26 bits, baud * ratio fits 28 bits
  localparam int unsigned NUM_W = 26;
  localparam int unsigned DEN_W = 28;
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam int unsigned DIV_W = 24;  // clock / (baud * 4) stays below 2^24
  localparam int unsigned LIM_W = 18;  // (baud / 100) * 3

  localparam logic [KHZ_W-1:0]   CLK_KHZ_MIN   = 16'd32;
  localparam logic [KHZ_W-1:0]   CLK_KHZ_MAX   = 16'd50000;
  localparam logic [RATIO_W-1:0] RATIO_MIN     = 6'd4;
  localparam logic [RATIO_W-1:0] RATIO_MAX     = 6'd32;
  localparam logic [RATIO_W-1:0] BOTH_EDGE_MAX = 6'd8;
  localparam int unsigned        KHZ_TO_HZ     = 1000;
  localparam int unsigned        PCT_DIV       = 100;
  localparam int unsigned        PCT_LIMIT     = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CLOCK = 2'd1,
    ST_BAD_ERROR = 2'd2,
    ST_DIV_WIDE  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LIMIT_WAIT,
    S_MUL1,
    S_WAIT1,
    S_MUL2,
    S_WAIT2,
    S_UPDATE,
    S_NEXT,
    S_FINISH
  } fsm_e;

  typedef struct packed {
    logic [KHZ_W-1:0]  clock_khz;
    logic [BAUD_W-1:0] target_baud;
  } in_t;

  typedef struct packed {
    logic [RATIO_W-1:0] oversample_ratio;
    logic [BDIV_W-1:0]  baud_divisor;
    logic               both_edge;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

endpackage

### rtl/ubds_div.sv
module ubds_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ubds_pkg::div_req_t  req_i,
  output logic                done_o,
  output logic [ubds_pkg::NUM_W-1:0] quotient_o
);
  import ubds_pkg::*;

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q;
  logic             done_q;

  logic [DEN_W:0]   shifted;
  logic             ge;
  logic [DEN_W:0]   diff;

  // One quotient bit per cycle, restoring form
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(NUM_W - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

### rtl/uart_baud_divisor_search_unit.sv
// Channel  | Ports                     | Handshake
// ---------+---------------------------+------------------------------------
// request  | item_i (clock_khz, baud)  | beat taken when start & !busy
// result   | result_o (ratio, divisor, | beat shown for one cycle with done_o
//          |   both_edge, status)      |
//
// One request with a good clock and nonzero baud runs the limit division and
// then, for each of the 29 ratios, a divisor division and an achieved-rate
// division, with sequencing states around them. Each division runs on the
// shared bit-serial divider, one shift per quotient bit and then its done
// strobe. A ratio whose divisor comes out zero skips the second division.
// A bad clock shows its result straight from the check state, and a zero baud
// shows its result through the finish state. Busy drops with the strobe,
// so the next beat can be taken at the edge that ends it. Reset clears the
// sequencer and the result strobe. The receiver cannot stall; each result is
// shown exactly once.
module uart_baud_divisor_search_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ubds_pkg::in_t  item_i,
  output ubds_pkg::out_t result_o,
  output logic           done_o
);
  import ubds_pkg::*;

  fsm_e state_q, state_d;

  // Request operands
  logic [KHZ_W-1:0]  khz_q;
  logic [BAUD_W-1:0] baud_q;
  logic [NUM_W-1:0]  clk_hz_q;

  // Search state
  logic [RATIO_W-1:0] ratio_q;
  logic [DIV_W-1:0]   div_q;
  logic [NUM_W-1:0]   err_q;
  logic [LIM_W-1:0]   limit_q;
  logic               found_q;
  logic [RATIO_W-1:0] best_ratio_q;
  logic [DIV_W-1:0]   best_div_q;
  logic [NUM_W-1:0]   best_err_q;

  // Result register
  out_t result_q, result_d;
  logic result_load;
  logic done_q;

  // Shared divider
  div_req_t         div_req;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;

  logic             khz_bad;
  logic [NUM_W-1:0] baud_ext;
  logic [NUM_W-1:0] err_abs;

  ubds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign khz_bad  = (khz_q < CLK_KHZ_MIN) || (khz_q > CLK_KHZ_MAX);
  assign baud_ext = NUM_W'(baud_q);
  // Error of the achieved rate against the target
  assign err_abs  = (div_quot > baud_ext) ? (div_quot - baud_ext) : (baud_ext - div_quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= result_load;
    end
  end

  // Sequencer: next state, divider requests and result assembly
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = clk_hz_q;
    div_req.divisor  = '0;
    result_load      = 1'b0;
    result_d         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (khz_bad) begin
          result_d.status = ST_BAD_CLOCK;
          result_load     = 1'b1;
          state_d         = S_IDLE;
        end else if (baud_q == '0) begin
          state_d = S_FINISH;
        end else begin
          // Limit uses the integer percent: (baud / 100) * 3
          div_req.start    = 1'b1;
          div_req.dividend = baud_ext;
          div_req.divisor  = DEN_W'(PCT_DIV);
          state_d          = S_LIMIT_WAIT;
        end
      end
      S_LIMIT_WAIT: begin
        if (div_done) state_d = S_MUL1;
      end
      S_MUL1: begin
        // divisor = clock / (baud * ratio); the divider registers the product
        div_req.start   = 1'b1;
        div_req.divisor = DEN_W'(29'(baud_q) * 29'(ratio_q));
        state_d         = S_WAIT1;
      end
      S_WAIT1: begin
        if (div_done) begin
          // Skip a ratio whose divisor comes out zero
          state_d = (div_quot == '0) ? S_NEXT : S_MUL2;
        end
      end
      S_MUL2: begin
        // achieved = clock / (ratio * divisor); the product never exceeds clock
        div_req.start   = 1'b1;
        div_req.divisor = DEN_W'(30'(ratio_q) * 30'(div_q));
        state_d         = S_WAIT2;
      end
      S_WAIT2: begin
        if (div_done) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        state_d = S_NEXT;
      end
      S_NEXT: begin
        state_d = (ratio_q == RATIO_MAX) ? S_FINISH : S_MUL1;
      end
      S_FINISH: begin
        result_load = 1'b1;
        state_d     = S_IDLE;
        if (!found_q) begin
          result_d.status = ST_BAD_ERROR;
        end else begin
          result_d.oversample_ratio = best_ratio_q;
          result_d.baud_divisor     = best_div_q[BDIV_W-1:0];
          result_d.both_edge        = best_ratio_q <= BOTH_EDGE_MAX;
          if (best_err_q >= NUM_W'(limit_q)) begin
            result_d.status = ST_BAD_ERROR;
          end else if (best_div_q[DIV_W-1:BDIV_W] != '0) begin
            result_d.status = ST_DIV_WIDE;
          end else begin
            result_d.status = ST_OK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath registers, advanced by the sequencer state
  always_ff @(posedge clk_i) begin
    if (result_load) result_q <= result_d;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          khz_q  <= item_i.clock_khz;
          baud_q <= item_i.target_baud;
        end
      end
      S_CHECK: begin
        clk_hz_q <= NUM_W'(32'(khz_q) * 32'(KHZ_TO_HZ));
        ratio_q  <= RATIO_MIN;
        found_q  <= 1'b0;
      end
      S_LIMIT_WAIT: begin
        if (div_done) limit_q <= LIM_W'(32'(div_quot) * 32'(PCT_LIMIT));
      end
      S_WAIT1: begin
        if (div_done) div_q <= div_quot[DIV_W-1:0];
      end
      S_WAIT2: begin
        if (div_done) err_q <= err_abs;
      end
      S_UPDATE: begin
        // Ties go to the later, larger ratio
        if (!found_q || (err_q <= best_err_q)) begin
          found_q      <= 1'b1;
          best_err_q   <= err_q;
          best_ratio_q <= ratio_q;
          best_div_q   <= div_q;
        end
      end
      S_NEXT: begin
        ratio_q <= ratio_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign busy     = state_q != S_IDLE;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
